@@ hdl/http_request_line_parser_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the HTTP request line parser
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_PARSER_UNIT_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HRLP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HRLP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/http_rlp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_rlp_pkg
// Types, character constants and method tables for the request line parser.
// ----------------------------------------------------------------------------
package http_rlp_pkg;

    // Method codes reported in the end record
    localparam logic [2:0] METH_GET     = 3'd0;
    localparam logic [2:0] METH_PUT     = 3'd1;
    localparam logic [2:0] METH_POST    = 3'd2;
    localparam logic [2:0] METH_DELETE  = 3'd3;
    localparam logic [2:0] METH_UNKNOWN = 3'd4;

    // Result kinds
    localparam logic KIND_URI = 1'b0;
    localparam logic KIND_END = 1'b1;

    // Character constants
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_CASE  = 8'h20;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Parse phase
    typedef enum logic [1:0] {
        PH_METHOD,
        PH_SKIP,
        PH_URI,
        PH_DONE
    } t_phase;

    // One classified byte: an optional URI byte and an optional end record
    typedef struct packed {
        logic       has_uri;
        logic [7:0] uri_char;
        logic       has_end;
        logic [2:0] method_code;
        logic       ok;
    } t_entry;

    // Queue status seen by the front
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Length of each method name
    function automatic logic [2:0] method_len(input logic [1:0] idx);
        logic [2:0] len;
        unique case (idx)
            2'd0:    len = 3'd3;
            2'd1:    len = 3'd3;
            2'd2:    len = 3'd4;
            default: len = 3'd6;
        endcase
        return len;
    endfunction

    // Lower-case text of each method name, position by position
    function automatic logic [7:0] method_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (idx)
            2'd0: begin
                unique case (pos)
                    3'd0:    c = "g";
                    3'd1:    c = "e";
                    3'd2:    c = "t";
                    default: c = 8'h00;
                endcase
            end
            2'd1: begin
                unique case (pos)
                    3'd0:    c = "p";
                    3'd1:    c = "u";
                    3'd2:    c = "t";
                    default: c = 8'h00;
                endcase
            end
            2'd2: begin
                unique case (pos)
                    3'd0:    c = "p";
                    3'd1:    c = "o";
                    3'd2:    c = "s";
                    3'd3:    c = "t";
                    default: c = 8'h00;
                endcase
            end
            default: begin
                unique case (pos)
                    3'd0:    c = "d";
                    3'd1:    c = "e";
                    3'd2:    c = "l";
                    3'd3:    c = "e";
                    3'd4:    c = "t";
                    3'd5:    c = "e";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

@@ hdl/http_rlp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_rlp_in_if / http_rlp_out_if
// Valid/ready channels for request bytes and parse results.
// ----------------------------------------------------------------------------
interface http_rlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface http_rlp_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] uri_char;
    logic [2:0] method_code;
    logic       ok;

    modport source (output valid, output kind, output uri_char, output method_code,
                    output ok, input ready);
    modport sink   (input valid, input kind, input uri_char, input method_code,
                    input ok, output ready);
endinterface

@@ hdl/http_rlp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_rlp_front
// Accept request bytes, track the parse phase and method match, and push
// one classified entry per byte that causes a result.
// ----------------------------------------------------------------------------
module http_rlp_front #(
    parameter int URI_MAX_LEN = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    http_rlp_in_if.sink            i_in,
    input  http_rlp_pkg::t_q_status i_q_status,
    output logic                   o_push,
    output http_rlp_pkg::t_entry   o_entry
);

    localparam int CntW = (URI_MAX_LEN > 2) ? $clog2(URI_MAX_LEN) : 1;
    localparam logic [CntW-1:0] UriLimit = CntW'(URI_MAX_LEN - 1);

    http_rlp_pkg::t_phase r_phase, n_phase, w_phase_step;
    logic [2:0]      r_len, n_len;
    logic [3:0]      r_mask, n_mask;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_ended, n_ended;

    logic       w_accept;
    logic [7:0] w_lc;
    logic       w_is_ws;
    logic       w_active;
    logic       w_uri_take;
    logic       w_uri_emit;
    logic       w_found;
    logic [2:0] w_code;

    // Take a byte whenever the queue has room
    assign i_in.ready = !i_q_status.full;
    assign w_accept   = i_in.valid && i_in.ready;

    // Classify the byte
    assign w_lc = (i_in.ch >= http_rlp_pkg::CH_UP_A && i_in.ch <= http_rlp_pkg::CH_UP_Z)
                  ? (i_in.ch + http_rlp_pkg::CH_CASE) : i_in.ch;
    assign w_is_ws = (i_in.ch == http_rlp_pkg::CH_SPACE) ||
                     (i_in.ch >= http_rlp_pkg::CH_TAB && i_in.ch <= http_rlp_pkg::CH_CR);
    assign w_active = !r_ended && (i_in.ch != http_rlp_pkg::CH_NUL);

    // Next phase
    always_comb begin
        w_phase_step = r_phase;
        w_uri_take   = 1'b0;
        if (w_active) begin
            unique case (r_phase)
                http_rlp_pkg::PH_METHOD: begin
                    if (i_in.ch == http_rlp_pkg::CH_SPACE) begin
                        w_phase_step = http_rlp_pkg::PH_SKIP;
                    end
                end
                http_rlp_pkg::PH_SKIP: begin
                    if (!w_is_ws) begin
                        w_phase_step = http_rlp_pkg::PH_URI;
                        w_uri_take   = 1'b1;
                    end
                end
                http_rlp_pkg::PH_URI: begin
                    if (i_in.ch == http_rlp_pkg::CH_SPACE) begin
                        w_phase_step = http_rlp_pkg::PH_DONE;
                    end else begin
                        w_uri_take = 1'b1;
                    end
                end
                http_rlp_pkg::PH_DONE: begin
                    w_phase_step = http_rlp_pkg::PH_DONE;
                end
                default: begin
                    w_phase_step = r_phase;
                end
            endcase
        end
        n_phase = i_in.last ? http_rlp_pkg::PH_METHOD : w_phase_step;
    end

    // Method match, URI count and end-of-string flag
    always_comb begin
        n_len   = r_len;
        n_mask  = r_mask;
        n_cnt   = r_cnt;
        n_ended = r_ended;
        if (!r_ended && i_in.ch == http_rlp_pkg::CH_NUL) begin
            n_ended = 1'b1;
        end
        if (w_active && r_phase == http_rlp_pkg::PH_METHOD) begin
            for (int i = 0; i < 4; i++) begin
                if (i_in.ch == http_rlp_pkg::CH_SPACE) begin
                    if (http_rlp_pkg::method_len(2'(i)) != r_len) begin
                        n_mask[i] = 1'b0;
                    end
                end else if (r_len >= http_rlp_pkg::method_len(2'(i)) ||
                             http_rlp_pkg::method_char(2'(i), r_len) != w_lc) begin
                    n_mask[i] = 1'b0;
                end
            end
            if (i_in.ch != http_rlp_pkg::CH_SPACE && r_len != 3'd7) begin
                n_len = r_len + 3'd1;
            end
        end
        if (w_uri_emit) begin
            n_cnt = r_cnt + CntW'(1);
        end
    end

    assign w_uri_emit = w_uri_take && (r_cnt < UriLimit);

    // Pick the method from the updated mask
    always_comb begin
        w_found = (w_phase_step != http_rlp_pkg::PH_METHOD);
        w_code  = http_rlp_pkg::METH_UNKNOWN;
        if (w_found) begin
            priority if (n_mask[0]) begin
                w_code = http_rlp_pkg::METH_GET;
            end else if (n_mask[1]) begin
                w_code = http_rlp_pkg::METH_PUT;
            end else if (n_mask[2]) begin
                w_code = http_rlp_pkg::METH_POST;
            end else if (n_mask[3]) begin
                w_code = http_rlp_pkg::METH_DELETE;
            end else begin
                w_code = http_rlp_pkg::METH_UNKNOWN;
            end
        end
    end

    // Form the queue entry
    always_comb begin
        o_entry.has_uri     = w_uri_emit;
        o_entry.uri_char    = i_in.ch;
        o_entry.has_end     = i_in.last;
        o_entry.method_code = w_code;
        o_entry.ok          = w_found;
        o_push              = w_accept && (w_uri_emit || i_in.last);
    end

    // Update parse state; the last byte returns it to the reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= http_rlp_pkg::PH_METHOD;
            r_len   <= 3'd0;
            r_mask  <= 4'hF;
            r_cnt   <= '0;
            r_ended <= 1'b0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            if (i_in.last) begin
                r_len   <= 3'd0;
                r_mask  <= 4'hF;
                r_cnt   <= '0;
                r_ended <= 1'b0;
            end else begin
                r_len   <= n_len;
                r_mask  <= n_mask;
                r_cnt   <= n_cnt;
                r_ended <= n_ended;
            end
        end
    end

endmodule

@@ hdl/http_rlp_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_rlp_fifo
// Short queue of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module http_rlp_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  http_rlp_pkg::t_entry    i_entry,
    input  logic                    i_pop,
    output http_rlp_pkg::t_entry    o_head,
    output http_rlp_pkg::t_q_status o_status
);

    http_rlp_pkg::t_entry r_mem [http_rlp_pkg::Q_DEPTH];
    logic [http_rlp_pkg::Q_AW-1:0] r_wr_ptr;
    logic [http_rlp_pkg::Q_AW-1:0] r_rd_ptr;
    logic [http_rlp_pkg::Q_AW:0]   r_count;
    logic                          w_push;
    logic                          w_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (http_rlp_pkg::Q_AW + 1)'(http_rlp_pkg::Q_DEPTH));
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_head = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/http_rlp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_rlp_back
// Expand each queue entry into a URI byte and/or an end record and drive
// the registered result channel.
// ----------------------------------------------------------------------------
module http_rlp_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  http_rlp_pkg::t_entry    i_head,
    input  http_rlp_pkg::t_q_status i_q_status,
    output logic                    o_pop,
    http_rlp_out_if.source          o_out
);

    logic       r_valid;
    logic       r_kind;
    logic [7:0] r_uri_char;
    logic [2:0] r_method_code;
    logic       r_ok;
    logic       r_half;
    logic       w_load;
    logic       w_send_uri;

    // Load a new transaction when the output register is free or draining
    assign w_load     = (!r_valid || o_out.ready) && !i_q_status.empty;
    assign w_send_uri = i_head.has_uri && !r_half;
    assign o_pop      = w_load && (!w_send_uri || !i_head.has_end);

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_kind;
    assign o_out.uri_char    = r_uri_char;
    assign o_out.method_code = r_method_code;
    assign o_out.ok          = r_ok;

    // Control: output valid and the URI-already-sent flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_half  <= w_send_uri && i_head.has_end;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_send_uri) begin
                r_kind        <= http_rlp_pkg::KIND_URI;
                r_uri_char    <= i_head.uri_char;
                r_method_code <= http_rlp_pkg::METH_GET;
                r_ok          <= 1'b0;
            end else begin
                r_kind        <= http_rlp_pkg::KIND_END;
                r_uri_char    <= http_rlp_pkg::CH_NUL;
                r_method_code <= i_head.method_code;
                r_ok          <= i_head.ok;
            end
        end
    end

endmodule

@@ hdl/http_request_line_parser_unit.sv @@
`timescale 1ns / 1ps
// A result passes through the queue and then the output register to o_out.
// The block takes one byte per cycle while the queue has room; a byte that
// yields both a URI byte and an end record occupies the output register twice,
// absorbed by the four-entry queue between the parse front and the result back.
// Reset: synchronous, active low; clears parse state, queue and output valid.
// ----------------------------------------------------------------------------
// http_request_line_parser_unit
// Parse an HTTP request line byte by byte into URI bytes and an end record.
// ----------------------------------------------------------------------------
module http_request_line_parser_unit #(
    parameter int URI_MAX_LEN = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    http_rlp_in_if.sink    i_in,
    http_rlp_out_if.source o_out
);

    logic                    w_push;
    logic                    w_pop;
    http_rlp_pkg::t_entry    w_entry;
    http_rlp_pkg::t_entry    w_head;
    http_rlp_pkg::t_q_status w_q_status;

    http_rlp_front #(
        .URI_MAX_LEN(URI_MAX_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    http_rlp_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    http_rlp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

endmodule

@@ hdl/http_rlp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_rlp_checker
// Port-level checks on the result channel of the request line parser.
// ----------------------------------------------------------------------------
`include "http_request_line_parser_unit_macros.svh"

module http_rlp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_kind,
    input logic [7:0] i_uri_char,
    input logic [2:0] i_method_code,
    input logic       i_ok
);

    // Hold a stalled transaction
    `HRLP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_kind, i_uri_char, i_method_code, i_ok}), "stalled result changed")

    // URI byte results carry no method or status
    `HRLP_ASSERT_SAME(a_uri_clean, i_clk, i_rst_n, i_out_valid && i_kind == http_rlp_pkg::KIND_URI, i_method_code == http_rlp_pkg::METH_GET && !i_ok, "URI result has method fields")

    // End records carry no URI byte and a legal method code
    `HRLP_ASSERT_SAME(a_end_clean, i_clk, i_rst_n, i_out_valid && i_kind == http_rlp_pkg::KIND_END, i_uri_char == http_rlp_pkg::CH_NUL && i_method_code <= http_rlp_pkg::METH_UNKNOWN, "bad end record")

    // Without a separating space the method is unknown
    `HRLP_ASSERT_SAME(a_no_space, i_clk, i_rst_n, i_out_valid && i_kind == http_rlp_pkg::KIND_END && !i_ok, i_method_code == http_rlp_pkg::METH_UNKNOWN, "method without space")

endmodule

bind http_request_line_parser_unit http_rlp_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_kind        (o_out.kind),
    .i_uri_char    (o_out.uri_char),
    .i_method_code (o_out.method_code),
    .i_ok          (o_out.ok)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the request line parser against its own cycle-free predictor.
// A short set of hand-written requests comes first, then well-formed requests
// with random method case, blank runs, URIs and trailers, mixed with broken
// and noise requests. Both channels idle at random, the receiver stalls long
// enough to back up the input, and the sender sometimes waits for a full drain.
// ----------------------------------------------------------------------------
module testbench;

    localparam int URI_LIMIT    = 64;
    localparam int TARGET_BYTES = 1450;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    // One request byte waiting to be sent
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       pause_before;
    } t_req_byte;

    // One parse result, as the block should produce it
    typedef struct packed {
        logic       kind;
        logic [7:0] uri_char;
        logic [2:0] method_code;
        logic       ok;
    } t_parse_result;

    logic i_clk;
    logic i_rst_n;

    http_rlp_in_if  req_bus ();
    http_rlp_out_if res_bus ();

    http_request_line_parser_unit #(
        .URI_MAX_LEN(URI_LIMIT)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_bus),
        .o_out  (res_bus)
    );

    t_req_byte     pending_bytes[$];
    t_parse_result expected_results[$];
    logic [7:0]    req_text[$];

    // Predictor state
    http_rlp_pkg::t_phase parse_phase;
    logic [2:0] name_len;
    logic [3:0] name_match;
    int         uri_emitted;
    logic       text_ended;

    logic results_drained;
    int   mismatch_count;
    int   bytes_accepted;
    int   requests_built;
    int   uri_seen;
    int   ends_seen;
    int   no_space_seen;
    int   code_seen[5];
    int   idle_cycles;

    int tx_gap;
    int tx_calm;
    int rx_hold;
    int rx_calm;
    int rx_cycle;

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic string method_name(input int idx);
        case (idx)
            0:       return "get";
            1:       return "put";
            2:       return "post";
            default: return "delete";
        endcase
    endfunction

    function automatic logic [2:0] method_code_of(input int idx);
        case (idx)
            0:       return http_rlp_pkg::METH_GET;
            1:       return http_rlp_pkg::METH_PUT;
            2:       return http_rlp_pkg::METH_POST;
            default: return http_rlp_pkg::METH_DELETE;
        endcase
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == http_rlp_pkg::CH_SPACE ||
               (c >= http_rlp_pkg::CH_TAB && c <= http_rlp_pkg::CH_CR);
    endfunction

    // Emit a URI byte unless the URI is already at its limit
    function automatic void emit_uri_byte(input logic [7:0] c);
        t_parse_result r;
        if (uri_emitted < URI_LIMIT - 1) begin
            r.kind        = http_rlp_pkg::KIND_URI;
            r.uri_char    = c;
            r.method_code = '0;
            r.ok          = 1'b0;
            expected_results.push_back(r);
            uri_emitted++;
        end
    endfunction

    function automatic void clear_parse_state();
        parse_phase = http_rlp_pkg::PH_METHOD;
        name_len    = '0;
        name_match  = 4'hF;
        uri_emitted = 0;
        text_ended  = 1'b0;
    endfunction

    // Advance the parse by one accepted byte and queue what it yields
    function automatic void predict_request_byte(input logic [7:0] c, input logic fin);
        logic [7:0]    lc;
        string         name;
        t_parse_result r;
        int            i;
        if (!text_ended && c == http_rlp_pkg::CH_NUL) begin
            text_ended = 1'b1;
        end else if (!text_ended) begin
            case (parse_phase)
                http_rlp_pkg::PH_METHOD: begin
                    if (c == http_rlp_pkg::CH_SPACE) begin
                        for (i = 0; i < 4; i++) begin
                            name = method_name(i);
                            if (name.len() != name_len) name_match[i] = 1'b0;
                        end
                        parse_phase = http_rlp_pkg::PH_SKIP;
                    end else begin
                        lc = (c >= http_rlp_pkg::CH_UP_A && c <= http_rlp_pkg::CH_UP_Z)
                             ? c + http_rlp_pkg::CH_CASE : c;
                        for (i = 0; i < 4; i++) begin
                            name = method_name(i);
                            if (name_len >= name.len() || name[name_len] != lc)
                                name_match[i] = 1'b0;
                        end
                        if (name_len != 3'd7) name_len++;
                    end
                end
                http_rlp_pkg::PH_SKIP: begin
                    if (!is_blank(c)) begin
                        parse_phase = http_rlp_pkg::PH_URI;
                        emit_uri_byte(c);
                    end
                end
                http_rlp_pkg::PH_URI: begin
                    if (c == http_rlp_pkg::CH_SPACE) parse_phase = http_rlp_pkg::PH_DONE;
                    else emit_uri_byte(c);
                end
                default: ;
            endcase
        end
        if (fin) begin
            r.kind        = http_rlp_pkg::KIND_END;
            r.uri_char    = '0;
            r.method_code = http_rlp_pkg::METH_UNKNOWN;
            r.ok          = (parse_phase != http_rlp_pkg::PH_METHOD);
            if (r.ok) begin
                for (i = 3; i >= 0; i--)
                    if (name_match[i]) r.method_code = method_code_of(i);
            end
            expected_results.push_back(r);
            clear_parse_state();
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic void push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) req_text.push_back(s[i]);
    endfunction

    // Move the assembled request into the send queue, last flag on its final byte
    function automatic void queue_request(input logic pause);
        t_req_byte b;
        int        i;
        for (i = 0; i < req_text.size(); i++) begin
            b.ch           = req_text[i];
            b.last         = (i == req_text.size() - 1);
            b.pause_before = pause && (i == 0);
            pending_bytes.push_back(b);
        end
        req_text.delete();
        requests_built++;
    endfunction

    function automatic logic [7:0] random_case(input logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1)) return c - http_rlp_pkg::CH_CASE;
        return c;
    endfunction

    // Draw a random byte in a range
    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        return 8'($urandom_range(lo, hi));
    endfunction

    // Build one random request: mostly well formed, some broken or pure noise
    function automatic void build_random_request();
        string name;
        int    pick;
        int    n;
        int    i;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) req_text.push_back(rand_byte(0, 255));
            return;
        end
        // method
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            name = method_name($urandom_range(0, 3));
            for (i = 0; i < name.len(); i++) req_text.push_back(random_case(name[i]));
        end else if (pick < 84) begin
            name = method_name($urandom_range(0, 3));
            n = $urandom_range(0, name.len());
            for (i = 0; i < n; i++) req_text.push_back(random_case(name[i]));
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) req_text.push_back(random_case(rand_byte("a", "z")));
        end else if (pick < 92) begin
            n = $urandom_range(7, 12);
            for (i = 0; i < n; i++) req_text.push_back(random_case(rand_byte("a", "z")));
        end else begin
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++) req_text.push_back(rand_byte(1, 255));
        end
        // separator and leading blanks
        if ($urandom_range(0, 99) < 92) req_text.push_back(http_rlp_pkg::CH_SPACE);
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
            req_text.push_back($urandom_range(0, 1) ? http_rlp_pkg::CH_SPACE :
                               rand_byte(http_rlp_pkg::CH_TAB, http_rlp_pkg::CH_CR));
        // URI, occasionally past the length limit
        n = ($urandom_range(0, 99) < 6) ? $urandom_range(58, 72) : $urandom_range(0, 10);
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) req_text.push_back(rand_byte(8'h21, 8'h7E));
            else if (pick < 95)
                req_text.push_back(rand_byte(http_rlp_pkg::CH_TAB, http_rlp_pkg::CH_CR));
            else req_text.push_back(rand_byte(1, 255));
        end
        // trailer after the URI
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            push_text(" HTTP/1.1");
        end else if (pick < 35) begin
            req_text.push_back(http_rlp_pkg::CH_SPACE);
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++) req_text.push_back(rand_byte(0, 255));
        end
        // early string terminator
        if ($urandom_range(0, 99) < 8)
            req_text.insert($urandom_range(0, req_text.size()), http_rlp_pkg::CH_NUL);
        if (req_text.size() == 0) req_text.push_back(rand_byte(0, 255));
    endfunction

    // Stimulus and end of run
    initial begin
        i_rst_n         = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.ch      = '0;
        req_bus.last    = 1'b0;
        res_bus.ready   = 1'b0;
        results_drained = 1'b1;
        mismatch_count  = 0;
        bytes_accepted  = 0;
        requests_built  = 0;
        uri_seen        = 0;
        ends_seen       = 0;
        no_space_seen   = 0;
        code_seen       = '{0, 0, 0, 0, 0};
        idle_cycles     = 0;
        tx_gap          = 0;
        tx_calm         = 0;
        rx_hold         = 0;
        rx_calm         = 0;
        rx_cycle        = 0;
        clear_parse_state();

        // mixed-case GET, blanks skipped, CR and DEL inside URI, trailer dropped
        push_text("Get \tA");
        req_text.push_back(http_rlp_pkg::CH_CR);
        req_text.push_back(8'h7F);
        push_text(" z");
        queue_request(1'b0);
        // method name with no separating space
        push_text("PUT");
        queue_request(1'b0);
        // single non-ASCII byte
        req_text.push_back(8'hFF);
        queue_request(1'b0);
        // zero byte ends the string before the space
        push_text("P");
        req_text.push_back(http_rlp_pkg::CH_NUL);
        push_text(" a");
        queue_request(1'b0);
        // empty method, then only blanks
        req_text.push_back(http_rlp_pkg::CH_SPACE);
        req_text.push_back(http_rlp_pkg::CH_TAB);
        queue_request(1'b0);
        push_text("posT /");
        queue_request(1'b0);

        // random part; wait for a full drain now and then
        while (pending_bytes.size() < TARGET_BYTES) begin
            build_random_request();
            queue_request(requests_built == 6 || $urandom_range(0, 29) == 0);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || req_bus.valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d requests; checked %0d URI bytes and %0d end records",
                 bytes_accepted, requests_built, uri_seen, ends_seen);
        $display("End records: GET %0d, PUT %0d, POST %0d, DELETE %0d, unknown %0d (%0d no space)",
                 code_seen[0], code_seen[1], code_seen[2], code_seen[3], code_seen[4],
                 no_space_seen);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Request driver: hold each byte until accepted, then gap or pause for drain
    always @(posedge i_clk) begin
        logic      fire;
        t_req_byte b;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            req_bus.ch    <= '0;
            req_bus.last  <= 1'b0;
        end else begin
            fire = req_bus.valid && req_bus.ready;
            if (!req_bus.valid || fire) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    req_bus.valid <= 1'b0;
                end else if (pending_bytes.size() == 0) begin
                    req_bus.valid <= 1'b0;
                end else if (pending_bytes[0].pause_before && (fire || !results_drained)) begin
                    req_bus.valid <= 1'b0;
                end else begin
                    b = pending_bytes.pop_front();
                    req_bus.valid <= 1'b1;
                    req_bus.ch    <= b.ch;
                    req_bus.last  <= b.last;
                    if (tx_calm > 0) begin
                        tx_calm--;
                        tx_gap = 0;
                    end else begin
                        tx_gap = next_gap();
                        if ($urandom_range(0, 99) == 0) tx_calm = $urandom_range(40, 120);
                    end
                end
            end
        end
    end

    // Result ready: random stalls plus two long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle == 800 || rx_cycle == 2600) rx_hold = LONG_HOLD;
            if (rx_hold > 0) begin
                rx_hold--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
                if (rx_calm > 0) begin
                    rx_calm--;
                end else begin
                    rx_hold = next_gap();
                    if ($urandom_range(0, 99) == 0) rx_calm = $urandom_range(40, 120);
                end
            end
        end
    end

    // Monitor: predict on each accepted byte, then check each accepted result
    always @(posedge i_clk) begin
        t_parse_result want;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                predict_request_byte(req_bus.ch, req_bus.last);
                bytes_accepted++;
            end
            if (res_bus.valid && res_bus.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing pending, kind", res_bus.kind, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (res_bus.kind !== want.kind)
                        report_mismatch("kind", res_bus.kind, want.kind);
                    if (res_bus.uri_char !== want.uri_char)
                        report_mismatch("uri_char", res_bus.uri_char, want.uri_char);
                    if (res_bus.method_code !== want.method_code)
                        report_mismatch("method_code", res_bus.method_code, want.method_code);
                    if (res_bus.ok !== want.ok)
                        report_mismatch("ok", res_bus.ok, want.ok);
                    if (want.kind == http_rlp_pkg::KIND_END) begin
                        ends_seen++;
                        code_seen[want.method_code]++;
                        if (!want.ok) no_space_seen++;
                    end else begin
                        uri_seen++;
                    end
                end
            end
            results_drained <= (expected_results.size() == 0);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, expected_results.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
